// ===== design/tse_pkg.sv =====
package tse_pkg;

  localparam int MAX_DIGITS     = 3;
  localparam int ADC_FULL_SCALE = 1023;

  localparam int SAMPLE_W = 10;
  localparam int BYTE_W   = 8;
  localparam int SP_W     = 10;
  localparam int MEAS_W   = 7;
  localparam int DIGIT_W  = 4;
  localparam int DB_W     = 4;
  localparam int CNT_W    = $clog2(MAX_DIGITS + 1);
  localparam int DIG_IDX_W = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 10;

  localparam int PCT_FULL  = 100;
  localparam int ASCII_ZERO = 48;
  localparam int ASCII_NINE = 57;

  // Rounded percentage floor((200*x + FS) / (2*FS)) by a reciprocal multiply.
  localparam int    SCALE_DIV   = 2 * ADC_FULL_SCALE;
  localparam int    SCALE_SHIFT = 34;
  localparam longint SCALE_MULT =
    ((longint'(1) <<< SCALE_SHIFT) + longint'(SCALE_DIV) - 1) / longint'(SCALE_DIV);
  localparam int    SUM_W  = $clog2(200 * ((1 << SAMPLE_W) - 1) + ADC_FULL_SCALE + 1);
  localparam int    MULT_W = $clog2(SCALE_MULT + 1);
  localparam int    PROD_W = SUM_W + MULT_W;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DEADBAND       = 2'd0,
    CFG_LINE_END_CODE  = 2'd1,
    CFG_SETPOINT_LIMIT = 2'd2
  } cfg_index_t;

  typedef enum logic [1:0] {
    HEAT_IDLE = 2'd0,
    HEAT_ON   = 2'd1,
    COOL_ON   = 2'd2
  } heat_state_t;

  typedef enum logic [2:0] {
    ST_NONE      = 3'd0,
    ST_ECHO      = 3'd1,
    ST_OK        = 3'd2,
    ST_RANGE     = 3'd3,
    ST_BAD_CHAR  = 3'd4
  } entry_status_t;

  typedef struct packed {
    logic                local_mode;
    logic [BYTE_W-1:0]   rx_byte;
    logic [SP_W-1:0]     pot_pct;
    logic [MEAS_W-1:0]   meas_pct;
  } stage_t;

  typedef struct packed {
    logic [SP_W-1:0]   setpoint;
    logic [MEAS_W-1:0] measured_percent;
    heat_state_t       heat_state;
    logic              pwm_enable;
    logic [SP_W-1:0]   duty_percent;
    entry_status_t     entry_status;
  } result_t;

  function automatic logic [SP_W-1:0] to_percent(input logic [SAMPLE_W-1:0] x);
    logic [SUM_W-1:0]  n;
    logic [PROD_W-1:0] p;
    n = SUM_W'(x) * SUM_W'(200) + SUM_W'(ADC_FULL_SCALE);
    p = PROD_W'(n) * PROD_W'(SCALE_MULT);
    return SP_W'(p >> SCALE_SHIFT);
  endfunction

endpackage

// ===== design/tse_in_if.sv =====
interface tse_in_if;
  logic                           valid;
  logic                           ready;
  logic                           local_mode;
  logic [tse_pkg::SAMPLE_W-1:0]   pot_sample;
  logic [tse_pkg::BYTE_W-1:0]     rx_byte;
  logic [tse_pkg::SAMPLE_W-1:0]   heater_sample;

  modport source (output valid, local_mode, pot_sample, rx_byte, heater_sample,
                  input ready);
  modport sink (input valid, local_mode, pot_sample, rx_byte, heater_sample,
                output ready);
endinterface

// ===== design/tse_out_if.sv =====
interface tse_out_if;
  logic                         valid;
  logic                         ready;
  logic [tse_pkg::SP_W-1:0]     setpoint;
  logic [tse_pkg::MEAS_W-1:0]   measured_percent;
  logic [1:0]                   heat_state;
  logic                         pwm_enable;
  logic [tse_pkg::SP_W-1:0]     duty_percent;
  logic [2:0]                   entry_status;

  modport source (output valid, setpoint, measured_percent, heat_state, pwm_enable,
                  duty_percent, entry_status, input ready);
  modport sink (input valid, setpoint, measured_percent, heat_state, pwm_enable,
                duty_percent, entry_status, output ready);
endinterface

// ===== design/thermostat_with_setpoint_entry_top.sv =====
// Thermostat control pass with serial or potentiometer setpoint entry.
// Each request on in_if carries one control pass: the mode bit, a
// potentiometer sample, a received byte (zero means none) and a heater sample.
// Each request produces exactly one result on out_if with the setpoint, the
// measured percentage, the heating state, the PWM enable and duty, and the
// status of the serial entry.
// The block is a two-stage pipeline. The first stage registers the request
// together with both scaled percentages from the reciprocal multipliers; the
// second stage updates the digit buffer and setpoint and registers the result.
// A request is registered in the first stage and its result in the second;
// one request is accepted every cycle while the receiver keeps out_if.ready high.
// When the receiver stalls, the result register holds and the first stage
// keeps accepting until it is also full; then in_if.ready drops.
// Configuration writes on cfg_we, cfg_index and cfg_wdata take effect at once.
// Reset clears the pipeline, the digit count and the setpoint, and loads the
// deadband, line-end code and setpoint limit with 2, 13 and 100.
module thermostat_with_setpoint_entry_top (
  input  logic                            clk,
  input  logic                            rst_n,
  tse_in_if.sink                          in_if,
  tse_out_if.source                       out_if,
  input  logic                            cfg_we,
  input  logic [tse_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [tse_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
  import tse_pkg::*;

  logic [DB_W-1:0]    deadband_r;
  logic [BYTE_W-1:0]  line_end_r;
  logic [SP_W-1:0]    limit_r;

  logic               s1_valid_r;
  stage_t             s1_r;
  stage_t             s1_nxt;
  logic               out_valid_r;
  result_t            out_r;
  result_t            res_nxt;

  logic [DIGIT_W-1:0] digit_store_r [MAX_DIGITS];
  logic [CNT_W-1:0]   digit_count_r;
  logic [CNT_W-1:0]   digit_count_nxt;
  logic [SP_W-1:0]    target_r;
  logic [SP_W-1:0]    target_nxt;
  logic               digit_wr;

  logic               out_adv;
  logic               in_take;

  logic [SP_W-1:0]    pot_pct;
  logic [SP_W-1:0]    meas_raw;
  logic [SP_W-1:0]    typed_value;
  logic               is_digit;
  logic signed [SP_W+1:0] diff;
  logic signed [SP_W+1:0] db_s;

  assign out_adv      = s1_valid_r && (!out_valid_r || out_if.ready);
  assign in_if.ready  = !s1_valid_r || out_adv;
  assign in_take      = in_if.valid && in_if.ready;

  always_comb begin
    pot_pct  = to_percent(in_if.pot_sample);
    meas_raw = to_percent(in_if.heater_sample);
    s1_nxt.local_mode = in_if.local_mode;
    s1_nxt.rx_byte    = in_if.rx_byte;
    s1_nxt.pot_pct    = pot_pct;
    if (meas_raw > SP_W'(PCT_FULL)) begin
      s1_nxt.meas_pct = MEAS_W'(PCT_FULL);
    end else begin
      s1_nxt.meas_pct = MEAS_W'(meas_raw);
    end
  end

  always_comb begin
    typed_value = '0;
    for (int i = 0; i < MAX_DIGITS; i++) begin
      if (CNT_W'(i) < digit_count_r) begin
        typed_value = SP_W'(typed_value * SP_W'(10)) + SP_W'(digit_store_r[i]);
      end
    end
  end

  always_comb begin
    is_digit        = (s1_r.rx_byte >= BYTE_W'(ASCII_ZERO))
                   && (s1_r.rx_byte <= BYTE_W'(ASCII_NINE));
    target_nxt      = target_r;
    digit_count_nxt = digit_count_r;
    digit_wr        = 1'b0;
    res_nxt.entry_status = ST_NONE;
    if (s1_r.local_mode) begin
      target_nxt = s1_r.pot_pct;
    end else if (is_digit) begin
      if (digit_count_r < CNT_W'(MAX_DIGITS)) begin
        digit_wr             = 1'b1;
        digit_count_nxt      = digit_count_r + 1'b1;
        res_nxt.entry_status = ST_ECHO;
      end
    end else if (s1_r.rx_byte == line_end_r) begin
      target_nxt      = typed_value;
      digit_count_nxt = '0;
      if (typed_value > limit_r) begin
        res_nxt.entry_status = ST_RANGE;
      end else begin
        res_nxt.entry_status = ST_OK;
      end
    end else if (s1_r.rx_byte != '0) begin
      digit_count_nxt      = '0;
      res_nxt.entry_status = ST_BAD_CHAR;
    end

    diff = $signed({2'b00, target_nxt}) - $signed({5'b00000, s1_r.meas_pct});
    db_s = $signed({{(SP_W-DB_W+2){1'b0}}, deadband_r});
    if (diff > db_s) begin
      res_nxt.heat_state = HEAT_ON;
    end else if (diff < -db_s) begin
      res_nxt.heat_state = COOL_ON;
    end else begin
      res_nxt.heat_state = HEAT_IDLE;
    end
    res_nxt.setpoint         = target_nxt;
    res_nxt.measured_percent = s1_r.meas_pct;
    res_nxt.pwm_enable       = (res_nxt.heat_state != HEAT_IDLE);
    res_nxt.duty_percent     = res_nxt.pwm_enable ? target_nxt : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      deadband_r    <= DB_W'(2);
      line_end_r    <= BYTE_W'(13);
      limit_r       <= SP_W'(100);
      s1_valid_r    <= 1'b0;
      out_valid_r   <= 1'b0;
      digit_count_r <= '0;
      target_r      <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_DEADBAND:       deadband_r <= cfg_wdata[DB_W-1:0];
          CFG_LINE_END_CODE:  line_end_r <= cfg_wdata[BYTE_W-1:0];
          CFG_SETPOINT_LIMIT: limit_r    <= cfg_wdata[SP_W-1:0];
          default: ;
        endcase
      end
      if (in_take) begin
        s1_valid_r <= 1'b1;
      end else if (out_adv) begin
        s1_valid_r <= 1'b0;
      end
      if (out_adv) begin
        out_valid_r <= 1'b1;
      end else if (out_if.ready) begin
        out_valid_r <= 1'b0;
      end
      if (out_adv) begin
        digit_count_r <= digit_count_nxt;
        target_r      <= target_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_r <= s1_nxt;
    end
    if (out_adv) begin
      out_r <= res_nxt;
    end
    if (out_adv && digit_wr) begin
      digit_store_r[digit_count_r[DIG_IDX_W-1:0]] <= DIGIT_W'(s1_r.rx_byte - BYTE_W'(ASCII_ZERO));
    end
  end

  assign out_if.valid            = out_valid_r;
  assign out_if.setpoint         = out_r.setpoint;
  assign out_if.measured_percent = out_r.measured_percent;
  assign out_if.heat_state       = out_r.heat_state;
  assign out_if.pwm_enable       = out_r.pwm_enable;
  assign out_if.duty_percent     = out_r.duty_percent;
  assign out_if.entry_status     = out_r.entry_status;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    digit_count_r <= CNT_W'(MAX_DIGITS))
    else $error("digit count above buffer depth");

  a_duty_follows: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_r.pwm_enable ? (out_r.duty_percent == out_r.setpoint)
                                      : (out_r.duty_percent == '0)))
    else $error("duty does not match setpoint and enable");

  a_echo_counts: assert property (@(posedge clk) disable iff (!rst_n)
    (out_adv && (res_nxt.entry_status == ST_ECHO))
      |=> (digit_count_r == CNT_W'($past(digit_count_r) + 1'b1)))
    else $error("echoed digit not counted");

  a_local_keeps: assert property (@(posedge clk) disable iff (!rst_n)
    (out_adv && s1_r.local_mode) |=> $stable(digit_count_r))
    else $error("local pass changed digit count");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && out_valid_r && !out_if.ready) |=> s1_valid_r)
    else $error("first stage lost a request during stall");

endmodule
